// ----- design/tms_pkg.sv -----
// Package for the trimmed mean smoother: window geometry, derived widths,
// the reciprocal constant for the divide, and the controller command struct.
// Used by tms_ctrl, tms_datapath and trimmed_mean_smoother_unit.
package tms_pkg;

  // Window geometry and sample format.
  localparam int unsigned SAMPLE_W     = 24;
  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // The trimmed sum is divided by the count of entries that remain.
  localparam int unsigned DIVISOR = WINDOW_DEPTH - 2;
  localparam int unsigned HALF    = DIVISOR / 2;

  // Signed accumulator over the whole window, and the rounded magnitude.
  localparam int unsigned ACC_W = SAMPLE_W + $clog2(WINDOW_DEPTH) + 1;
  localparam int unsigned MAG_W = ACC_W - 1;

  // Reciprocal for the divide: quotient = (mag * RECIP) >> SHIFT, which is
  // at most one below the true quotient, so one correction step suffices.
  localparam int unsigned SHIFT   = MAG_W;
  localparam int unsigned RECIP_W = MAG_W + 1;
  localparam longint unsigned RECIP_VAL = (64'd1 << SHIFT) / DIVISOR;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;   // Input transfer: advance pointer, write ring.
    logic             scan;   // Accumulate one ring entry, track min and max.
    logic             first;  // First entry of the scan: initialize.
    logic [PTR_W-1:0] idx;    // Ring entry being scanned.
    logic             trim;   // Remove the maximum and minimum from the sum.
    logic             round;  // Take magnitude and add the rounding half.
    logic             mul1;   // Multiply by the reciprocal.
    logic             mul2;   // Multiply the estimate back by the divisor.
    logic             fix;    // Correct the quotient and load the result.
  } tms_cmd_t;

endpackage

// ----- design/tms_ctrl.sv -----
// Controller for the trimmed mean smoother: one-hot state machine, scan
// counter and output valid flag. Drives tms_datapath through tms_cmd_t.
// Depends on tms_pkg.
module tms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tms_pkg::tms_cmd_t cmd_o
);
  import tms_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_TRIM  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_MUL1  = 7'b0010000,
    ST_MUL2  = 7'b0100000,
    ST_FIX   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [PTR_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             load;
  logic             out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign load        = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state, scan counter and output valid.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (idx_q == PTR_W'(WINDOW_DEPTH - 1)) begin
          state_d = ST_TRIM;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TRIM:  state_d = ST_ROUND;
      ST_ROUND: state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_FIX;
      ST_FIX: begin
        // Hold here until the output register is free.
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = load;
    cmd_o.scan  = (state_q == ST_SCAN);
    cmd_o.first = (idx_q == '0);
    cmd_o.idx   = idx_q;
    cmd_o.trim  = (state_q == ST_TRIM);
    cmd_o.round = (state_q == ST_ROUND);
    cmd_o.mul1  = (state_q == ST_MUL1);
    cmd_o.mul2  = (state_q == ST_MUL2);
    cmd_o.fix   = (state_q == ST_FIX) && out_free;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/tms_datapath.sv -----
// Datapath for the trimmed mean smoother: sample ring, write pointer,
// accumulator with min and max tracking, reciprocal divide and result register.
// Depends on tms_pkg; sequenced by tms_ctrl.
module tms_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tms_pkg::tms_cmd_t                   cmd_i,
  input  logic signed [tms_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [tms_pkg::SAMPLE_W-1:0] smoothed_o
);
  import tms_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_VAL);
  localparam logic [MAG_W-1:0]   DIV_M   = MAG_W'(DIVISOR);
  localparam logic [MAG_W-1:0]   HALF_M  = MAG_W'(HALF);

  logic signed [SAMPLE_W-1:0] ring_q [WINDOW_DEPTH];
  logic [PTR_W-1:0]           ptr_q, ptr_next;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] lo_q, hi_q;
  logic signed [SAMPLE_W-1:0] entry;
  logic                       neg_q;
  logic [MAG_W-1:0]           mag_q, quo_q, rem_q;
  logic [ACC_W-1:0]           abs_v;
  logic [MAG_W+RECIP_W-1:0]   prod;
  logic [MAG_W-1:0]           quo_fix;
  logic [MAG_W-1:0]           res_v;
  logic signed [SAMPLE_W-1:0] smoothed_q;

  // Pointer wraps at the window depth.
  assign ptr_next = (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign entry    = ring_q[cmd_i.idx];

  // Ring and pointer: the new sample goes to the slot after the pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        ring_q[k] <= '0;
      end
    end else if (cmd_i.load) begin
      ptr_q            <= ptr_next;
      ring_q[ptr_next] <= sample_i;
    end
  end

  // Arithmetic helpers for the rounding, divide and correction steps.
  assign abs_v   = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign prod    = mag_q * RECIP_M;
  assign quo_fix = quo_q + MAG_W'(rem_q >= DIV_M);
  assign res_v   = neg_q ? -quo_fix : quo_fix;

  // Sequenced datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (cmd_i.first) begin
        acc_q <= ACC_W'(entry);
        lo_q  <= entry;
        hi_q  <= entry;
      end else begin
        acc_q <= acc_q + ACC_W'(entry);
        if (entry < lo_q) begin
          lo_q <= entry;
        end
        if (entry > hi_q) begin
          hi_q <= entry;
        end
      end
    end
    if (cmd_i.trim) begin
      acc_q <= acc_q - ACC_W'(hi_q) - ACC_W'(lo_q);
    end
    // Round half away from zero on the magnitude.
    if (cmd_i.round) begin
      neg_q <= acc_q[ACC_W-1];
      mag_q <= abs_v[MAG_W-1:0] + HALF_M;
    end
    if (cmd_i.mul1) begin
      quo_q <= prod[SHIFT +: MAG_W];
    end
    if (cmd_i.mul2) begin
      rem_q <= mag_q - MAG_W'(quo_q * DIV_M);
    end
    if (cmd_i.fix) begin
      smoothed_q <= res_v[SAMPLE_W-1:0];
    end
  end

  assign smoothed_o = smoothed_q;

endmodule

// ----- design/trimmed_mean_smoother_unit.sv -----
// Trimmed mean smoother: an eight-entry moving average of signed 24-bit
// samples that leaves out one largest and one smallest entry and rounds
// half away from zero.
//
// Channels: the input channel (in_valid_i, in_ready_o, sample_i) takes one
// sample per transfer; the output channel (out_valid_o, out_ready_i,
// smoothed_o) gives exactly one result per input sample, in order.
// Each sample passes through the scan, which reads the ring one entry per
// cycle through a single adder and min/max comparator, followed by trim,
// round, two multiply steps and the quotient correction; a new sample is
// taken only once the previous one has left the final step.
// Reset clears the ring and the write pointer to zero, so the first results
// average in the zero entries; no result is pending after reset.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and processed, and its result waits in the final
// step until the output register is free.
// Depends on tms_pkg, tms_ctrl and tms_datapath.
module trimmed_mean_smoother_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tms_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tms_pkg::SAMPLE_W-1:0] smoothed_o
);
  import tms_pkg::*;

  tms_cmd_t cmd;

  // Controller.
  tms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath.
  tms_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sample_i   (sample_i),
    .smoothed_o (smoothed_o)
  );

  // Only one processing step is commanded in any cycle.
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.scan, cmd.trim, cmd.round, cmd.mul1, cmd.mul2, cmd.fix}))
    else $error("more than one datapath step commanded");

  // After an input transfer the block is busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A new result appears only from the final correction step.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.fix))
    else $error("output valid raised without a result load");

endmodule

// ----- tb/sv/tb_trimmed_mean_smoother_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for trimmed_mean_smoother_unit: random and directed samples
// against an in-bench model of the drop-min/drop-max moving average.
// Depends on tms_pkg and the trimmed_mean_smoother_unit RTL.
module tb_trimmed_mean_smoother_unit;

  import tms_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 300;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Tracks the sample window and queues the smoothed value due for each sample.
  class smoother_scoreboard;
    logic signed [SAMPLE_W-1:0] window[WINDOW_DEPTH];
    logic [PTR_W-1:0]           wr_ptr;
    logic signed [SAMPLE_W-1:0] expected_smoothed[$];
    int                         fault_count;

    function new();
      foreach (window[k]) window[k] = '0;
      wr_ptr      = '0;
      fault_count = 0;
    endfunction

    // Advance the pointer, overwrite the oldest slot and compute the trimmed mean.
    function void note_sample(logic signed [SAMPLE_W-1:0] sample);
      longint sum;
      longint lo;
      longint hi;
      longint quot;
      longint divisor;
      longint half;
      divisor = DIVISOR;
      half    = HALF;
      wr_ptr  = (wr_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      window[wr_ptr] = sample;
      lo  = window[0];
      hi  = window[0];
      sum = 0;
      foreach (window[k]) begin
        sum += window[k];
        if (window[k] < lo) lo = window[k];
        if (window[k] > hi) hi = window[k];
      end
      sum = sum - hi - lo;
      // Round half away from zero, then truncate toward zero.
      if (sum >= 0) begin
        quot = (sum + half) / divisor;
      end else begin
        quot = (sum - half) / divisor;
      end
      expected_smoothed.push_back(quot[SAMPLE_W-1:0]);
    endfunction

    // Compare one output transfer with the oldest pending value.
    function void check_smoothed(logic signed [SAMPLE_W-1:0] actual);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_smoothed.size() == 0) begin
        $error("smoothed: unexpected result, expected none, actual %0d", actual);
        fault_count++;
      end else begin
        want = expected_smoothed.pop_front();
        if (actual !== want) begin
          $error("smoothed: expected %0d, actual %0d", want, actual);
          fault_count++;
        end
      end
    endfunction

    function int pending();
      return expected_smoothed.size();
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [SAMPLE_W-1:0] smoothed_o;

  smoother_scoreboard sb = new();

  int idle_pct;
  int stall_pct;
  bit hold_req;
  int cycle_count;

  trimmed_mean_smoother_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .smoothed_o  (smoothed_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check every output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_smoothed(smoothed_o);
    end
  end

  // Offer one sample, wait for its transfer, then idle at random.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(value);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Stop offering until every pending result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] value;
    logic signed [SAMPLE_W-1:0] prev;
    logic [31:0]                raw;
    int                         phase_idle[6];
    int                         phase_stall[6];

    phase_idle  = '{0, 65, 0, 12, 0, 65};
    phase_stall = '{0, 0, 65, 12, 0, 65};

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    out_ready_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_req    = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Start-up window: the first results still average in the reset zeros.
    send_sample(24'sd1);
    send_sample(24'sd2);
    send_sample(24'sd3);
    // A window full of equal extremes: one copy goes as max, one as min.
    repeat (WINDOW_DEPTH) send_sample(SAMPLE_MAX);
    repeat (WINDOW_DEPTH) send_sample(SAMPLE_MIN);
    // Sign changes and halfway rounding on small sums.
    send_sample(24'sd0);
    send_sample(-24'sd1);
    send_sample(24'sd3);
    send_sample(-24'sd3);
    send_sample(24'sd9);
    drain_results();

    prev = '0;
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Receiver holds off while the sender keeps going, so the block backs up.
        if (ph == 4 && n == 20) hold_req = 1'b1;
        case ($urandom_range(9))
          0, 1, 2: begin
            raw   = $urandom();
            value = raw[SAMPLE_W-1:0];
          end
          3: begin
            case ($urandom_range(4))
              0: value = SAMPLE_MAX;
              1: value = SAMPLE_MIN;
              2: value = '0;
              3: value = -24'sd1;
              default: value = 24'sd1;
            endcase
          end
          4, 5: value = SAMPLE_W'($urandom_range(24) - 12);
          6, 7: value = prev + SAMPLE_W'($urandom_range(2000) - 1000);
          8: value = prev;
          default: begin
            if ($urandom_range(1)) begin
              value = SAMPLE_MAX - SAMPLE_W'($urandom_range(100));
            end else begin
              value = SAMPLE_MIN + SAMPLE_W'($urandom_range(100));
            end
          end
        endcase
        send_sample(value);
        prev = value;
      end
      drain_results();
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.fault_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- trimmed_mean_smoother_unit.f -----
design/tms_pkg.sv
design/tms_ctrl.sv
design/tms_datapath.sv
design/trimmed_mean_smoother_unit.sv
tb/sv/tb_trimmed_mean_smoother_unit.sv
